// File: sv/qesp_pkg.sv
// ----------------------------------------------------------------------------
// qesp_pkg
// Shared types and constants for the quadrature encoder speed and position
// block: register indexes, operation codes, field selects and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package qesp_pkg;

    // Default width of the position counter.
    localparam int COUNT_WIDTH_DEF = 32;

    // Configuration registers.
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_W-1:0] CPR_RESET = 16'd1980;
    localparam logic [CFG_W-1:0] PPM_RESET = 16'd4000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CPR = 1'b0,
        CFG_PPM = 1'b1
    } cfg_idx_t;

    // Item operation codes.
    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TICK   = 1'b1
    } op_t;

    // Result field widths.
    localparam int PERIOD_W = 32;
    localparam int POS_W    = 32;
    localparam int REVS_W   = 37;
    localparam int ANGLE_W  = 48;
    localparam int SPEED_W  = 48;

    // Scale factors. The speed factor is periods_per_minute * 100, which stays
    // below 2^23 for any 16-bit register value.
    localparam int K_W         = 23;
    localparam int REVS_K      = 100;
    localparam int ANGLE_K     = 36000;
    localparam int SPEED_SCALE = 100;

    // Sign extension width used for the reported position.
    localparam int EXT_W = 64;

    // Which scaled result the shared multiply/divide unit is working on.
    typedef enum logic [1:0] {
        FIELD_REVS  = 2'd0,
        FIELD_ANGLE = 2'd1,
        FIELD_SPEED = 2'd2
    } field_t;

    typedef struct packed {
        logic   sample;     // decode one channel sample
        logic   tick;       // take the tick snapshot
        logic   load;       // start a multiply for the selected field
        logic   mul_step;   // one shift-add step
        logic   div_step;   // one restoring division step
        logic   store;      // saturate and keep the selected field
        logic   out_load;   // move the finished report to the output register
        field_t field;
    } cmd_t;

    typedef struct packed {
        logic out_free;     // output register can take a report this cycle
        logic out_valid;    // output register holds a report
    } status_t;

endpackage

// File: sv/qesp_if.sv
// ----------------------------------------------------------------------------
// qesp_if
// Item channels of the quadrature encoder block: the sample/tick input channel
// and the report output channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface qesp_in_if;
    logic valid;
    logic ready;
    logic op;
    logic level_a;
    logic level_b;

    modport source (output valid, output op, output level_a, output level_b,
                    input ready);
    modport sink   (input valid, input op, input level_a, input level_b,
                    output ready);
endinterface

interface qesp_out_if;
    logic                valid;
    logic                ready;
    logic        [31:0]  period_number;
    logic signed [31:0]  position_count;
    logic signed [36:0]  revs_centi;
    logic signed [47:0]  angle_centideg;
    logic signed [47:0]  speed_centirpm;
    logic                illegal_seen;

    modport source (output valid, output period_number, output position_count,
                    output revs_centi, output angle_centideg,
                    output speed_centirpm, output illegal_seen, input ready);
    modport sink   (input valid, input period_number, input position_count,
                    input revs_centi, input angle_centideg,
                    input speed_centirpm, input illegal_seen, output ready);
endinterface

// File: sv/qesp_ctrl.sv
// ----------------------------------------------------------------------------
// qesp_ctrl
// Controller: accepts items, and on a tick sequences the shared shift-add
// multiplier and restoring divider over the three scaled results.
// ----------------------------------------------------------------------------
module qesp_ctrl #(
    parameter int COUNT_WIDTH = qesp_pkg::COUNT_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_op,
    output logic               in_ready,
    input  qesp_pkg::status_t  status,
    output qesp_pkg::cmd_t     cmd
);

    localparam int NW    = COUNT_WIDTH + qesp_pkg::K_W;
    localparam int CNT_W = $clog2(NW);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_DIV,
        ST_STORE,
        ST_OUT
    } state_t;

    state_t           state_reg, state_next;
    qesp_pkg::field_t field_reg, field_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        field_next = field_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.field  = field_reg;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_op == qesp_pkg::OP_TICK)
                    begin
                        cmd.tick   = 1'b1;
                        field_next = qesp_pkg::FIELD_REVS;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        cmd.sample = 1'b1;
                    end
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                cnt_next   = CNT_W'(qesp_pkg::K_W - 1);
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    cnt_next   = CNT_W'(NW - 1);
                    state_next = ST_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_STORE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_STORE:
            begin
                cmd.store = 1'b1;
                case (field_reg)
                    qesp_pkg::FIELD_REVS:
                    begin
                        field_next = qesp_pkg::FIELD_ANGLE;
                        state_next = ST_LOAD;
                    end
                    qesp_pkg::FIELD_ANGLE:
                    begin
                        field_next = qesp_pkg::FIELD_SPEED;
                        state_next = ST_LOAD;
                    end
                    default:
                    begin
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            field_reg <= qesp_pkg::FIELD_REVS;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            field_reg <= field_next;
            cnt_reg   <= cnt_next;
        end
    end

    // A tick holds off further items until its report is handed over.
    a_tick_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_op == qesp_pkg::OP_TICK) |=> !in_ready)
        else $error("item accepted right after a tick");

    // The report is only pushed when the output register can take it.
    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("report loaded over an unread report");

    // An empty output register can always take a report.
    a_free_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !status.out_valid |-> status.out_free)
        else $error("empty output register reported as busy");

    // Division always follows a complete multiply.
    a_div_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && $past(state_reg) != ST_DIV)
            |-> ($past(state_reg) == ST_MUL && $past(cnt_reg) == '0))
        else $error("division started without a finished multiply");

endmodule

// File: sv/qesp_dp.sv
// ----------------------------------------------------------------------------
// qesp_dp
// Datapath: configuration registers, 4x quadrature decoder, tick snapshot,
// shared shift-add multiplier / restoring divider, and the report registers.
// ----------------------------------------------------------------------------
module qesp_dp #(
    parameter int COUNT_WIDTH = qesp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  qesp_pkg::cmd_t                    cmd,
    output qesp_pkg::status_t                 status,
    input  logic                              level_a,
    input  logic                              level_b,
    input  logic                              cfg_we,
    input  logic [qesp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [qesp_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [qesp_pkg::PERIOD_W-1:0]     out_period,
    output logic [qesp_pkg::POS_W-1:0]        out_pos,
    output logic [qesp_pkg::REVS_W-1:0]       out_revs,
    output logic [qesp_pkg::ANGLE_W-1:0]      out_angle,
    output logic [qesp_pkg::SPEED_W-1:0]      out_speed,
    output logic                              out_illegal
);

    localparam int CW   = COUNT_WIDTH;
    localparam int KW   = qesp_pkg::K_W;
    localparam int NW   = CW + KW;
    localparam int CMPW = (NW > qesp_pkg::ANGLE_W ? NW : qesp_pkg::ANGLE_W) + 1;
    localparam int CFW  = qesp_pkg::CFG_W;

    // Configuration.
    logic [CFW-1:0] cpr_reg, ppm_reg;

    // Decoder and tick state.
    logic [1:0]                    prev_reg, prev_next;
    logic [CW-1:0]                 pos_reg, pos_next;
    logic [CW-1:0]                 last_reg, last_next;
    logic [qesp_pkg::PERIOD_W-1:0] tick_reg, tick_next;
    logic                          ill_reg, ill_next;

    // Snapshot and arithmetic unit.
    logic          pos_neg_reg, dlt_neg_reg;
    logic [CW-1:0] pos_mag_reg, dlt_mag_reg, op_mag_reg;
    logic [KW-1:0] spd_k_reg, k_reg;
    logic [NW-1:0] acc_reg;
    logic [CFW-1:0] rem_reg;

    // Report being assembled and the output register.
    logic [qesp_pkg::PERIOD_W-1:0] st_period_reg;
    logic [qesp_pkg::POS_W-1:0]    st_pos_reg;
    logic [qesp_pkg::REVS_W-1:0]   st_revs_reg;
    logic [qesp_pkg::ANGLE_W-1:0]  st_angle_reg;
    logic [qesp_pkg::SPEED_W-1:0]  st_speed_reg;
    logic                          st_ill_reg;
    logic                          out_valid_reg;

    logic [1:0]                   cur;
    logic [CW-1:0]                delta;
    logic [qesp_pkg::EXT_W-1:0]   pos_ext;
    logic [CFW:0]                 rem_sh;
    logic                         ge;
    logic                         neg;
    logic [CMPW-1:0]              cap, quot, clip, res;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpr_reg <= qesp_pkg::CPR_RESET;
            ppm_reg <= qesp_pkg::PPM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                qesp_pkg::CFG_CPR: cpr_reg <= cfg_data;
                qesp_pkg::CFG_PPM: ppm_reg <= cfg_data;
                default:           cpr_reg <= cpr_reg;
            endcase
        end
    end

    // ---------------- decoder and tick bookkeeping ----------------
    assign cur     = {level_a, level_b};
    assign delta   = pos_reg - last_reg;
    assign pos_ext = {{(qesp_pkg::EXT_W - CW){pos_reg[CW-1]}}, pos_reg};

    always_comb
    begin
        prev_next = prev_reg;
        pos_next  = pos_reg;
        last_next = last_reg;
        tick_next = tick_reg;
        ill_next  = ill_reg;
        if (cmd.sample)
        begin
            prev_next = cur;
            case (cur ^ prev_reg)
                2'b11: ill_next = 1'b1;
                2'b10: pos_next = (level_a != level_b) ? pos_reg + 1'b1
                                                       : pos_reg - 1'b1;
                2'b01: pos_next = (level_a == level_b) ? pos_reg + 1'b1
                                                       : pos_reg - 1'b1;
                default: pos_next = pos_reg;
            endcase
        end
        else if (cmd.tick)
        begin
            tick_next = tick_reg + 1'b1;
            last_next = pos_reg;
            ill_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            pos_reg       <= '0;
            last_reg      <= '0;
            tick_reg      <= '0;
            ill_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            prev_reg <= prev_next;
            pos_reg  <= pos_next;
            last_reg <= last_next;
            tick_reg <= tick_next;
            ill_reg  <= ill_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- multiply / divide unit ----------------
    assign rem_sh = {rem_reg, acc_reg[NW-1]};
    assign ge     = (rem_sh >= {1'b0, cpr_reg});

    // Saturate the quotient to the selected field's signed range.
    always_comb
    begin
        neg = (cmd.field == qesp_pkg::FIELD_SPEED) ? dlt_neg_reg : pos_neg_reg;
        case (cmd.field)
            qesp_pkg::FIELD_REVS:
                cap = (CMPW'(1) << (qesp_pkg::REVS_W - 1)) - CMPW'(1);
            qesp_pkg::FIELD_ANGLE:
                cap = (CMPW'(1) << (qesp_pkg::ANGLE_W - 1)) - CMPW'(1);
            default:
                cap = (CMPW'(1) << (qesp_pkg::SPEED_W - 1)) - CMPW'(1);
        endcase
        cap  = cap + CMPW'(neg);
        quot = CMPW'(acc_reg);
        clip = (quot > cap) ? cap : quot;
        if (cpr_reg == '0)
        begin
            clip = '0;
        end
        res = neg ? (~clip + CMPW'(1)) : clip;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tick)
        begin
            pos_neg_reg   <= pos_reg[CW-1];
            pos_mag_reg   <= pos_reg[CW-1] ? (~pos_reg + 1'b1) : pos_reg;
            dlt_neg_reg   <= delta[CW-1];
            dlt_mag_reg   <= delta[CW-1] ? (~delta + 1'b1) : delta;
            spd_k_reg     <= KW'(ppm_reg) * KW'(qesp_pkg::SPEED_SCALE);
            st_period_reg <= tick_reg + 1'b1;
            st_pos_reg    <= pos_ext[qesp_pkg::POS_W-1:0];
            st_ill_reg    <= ill_reg;
        end

        if (cmd.load)
        begin
            acc_reg <= '0;
            rem_reg <= '0;
            case (cmd.field)
                qesp_pkg::FIELD_REVS:
                begin
                    k_reg      <= KW'(qesp_pkg::REVS_K);
                    op_mag_reg <= pos_mag_reg;
                end
                qesp_pkg::FIELD_ANGLE:
                begin
                    k_reg      <= KW'(qesp_pkg::ANGLE_K);
                    op_mag_reg <= pos_mag_reg;
                end
                default:
                begin
                    k_reg      <= spd_k_reg;
                    op_mag_reg <= dlt_mag_reg;
                end
            endcase
        end
        else if (cmd.mul_step)
        begin
            // Multiplier bits are taken most significant first.
            k_reg   <= {k_reg[KW-2:0], 1'b0};
            acc_reg <= {acc_reg[NW-2:0], 1'b0}
                       + (k_reg[KW-1] ? NW'(op_mag_reg) : NW'(0));
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? CFW'(rem_sh - {1'b0, cpr_reg}) : rem_sh[CFW-1:0];
            acc_reg <= {acc_reg[NW-2:0], ge};
        end

        if (cmd.store)
        begin
            case (cmd.field)
                qesp_pkg::FIELD_REVS:  st_revs_reg  <= res[qesp_pkg::REVS_W-1:0];
                qesp_pkg::FIELD_ANGLE: st_angle_reg <= res[qesp_pkg::ANGLE_W-1:0];
                default:               st_speed_reg <= res[qesp_pkg::SPEED_W-1:0];
            endcase
        end

        if (cmd.out_load)
        begin
            out_period  <= st_period_reg;
            out_pos     <= st_pos_reg;
            out_revs    <= st_revs_reg;
            out_angle   <= st_angle_reg;
            out_speed   <= st_speed_reg;
            out_illegal <= st_ill_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status.out_valid = out_valid_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

endmodule

// File: sv/quadrature_encoder_speed_position.sv
// ----------------------------------------------------------------------------
// quadrature_encoder_speed_position
// 4x quadrature decoder with a per-period report of position, revolutions,
// angle and speed in hundredths.
// ----------------------------------------------------------------------------
//
//   Channel     Dir   Handshake            Item contents
//   ---------   ---   ------------------   ----------------------------------
//   sample_ch   in    valid/ready          op, level_a, level_b
//   report_ch   out   valid/ready          period_number, position_count,
//                                          revs_centi, angle_centideg,
//                                          speed_centirpm, illegal_seen
//   cfg         in    cfg_we (no stall)    cfg_index, cfg_data
//
// Channel samples stream at one per clock while the block is idle. A tick item
// runs the shared shift-add multiplier and one-bit-per-cycle restoring divider
// three times; sample_ch.ready stays low during that time and while a
// finished report waits for the previous one to leave the output register.
// Reset is asynchronous and active low; it clears the position, the tick
// count and the sticky flag, and loads the register defaults (1980 counts per
// revolution, 4000 periods per minute).
// ----------------------------------------------------------------------------
module quadrature_encoder_speed_position #(
    parameter int COUNT_WIDTH = qesp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    qesp_in_if.sink                         sample_ch,
    qesp_out_if.source                      report_ch,
    input  logic                            cfg_we,
    input  logic [qesp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [qesp_pkg::CFG_W-1:0]      cfg_data
);

    // The controller owns the input handshake and sequences the datapath
    // through the tick snapshot, the three multiply/divide passes and the
    // hand-off to the output register.
    qesp_pkg::cmd_t    cmd;
    qesp_pkg::status_t status;

    logic [qesp_pkg::PERIOD_W-1:0] period;
    logic [qesp_pkg::POS_W-1:0]    pos;
    logic [qesp_pkg::REVS_W-1:0]   revs;
    logic [qesp_pkg::ANGLE_W-1:0]  angle;
    logic [qesp_pkg::SPEED_W-1:0]  speed;

    qesp_ctrl #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_ch.valid),
        .in_op    (sample_ch.op),
        .in_ready (sample_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath keeps the decoder state, takes a snapshot of position and
    // delta on each tick, and builds the saturated quotients one field at a
    // time. The finished report sits in an output register so that channel
    // samples keep flowing while it waits to be taken.
    qesp_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .level_a     (sample_ch.level_a),
        .level_b     (sample_ch.level_b),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_ready   (report_ch.ready),
        .out_valid   (report_ch.valid),
        .out_period  (period),
        .out_pos     (pos),
        .out_revs    (revs),
        .out_angle   (angle),
        .out_speed   (speed),
        .out_illegal (report_ch.illegal_seen)
    );

    assign report_ch.period_number  = period;
    assign report_ch.position_count = signed'(pos);
    assign report_ch.revs_centi     = signed'(revs);
    assign report_ch.angle_centideg = signed'(angle);
    assign report_ch.speed_centirpm = signed'(speed);

endmodule
